/* design/epc_pkg.sv */
// ----------------------------------------------------------------------------
// epc_pkg
// shared widths, divisor constants and reciprocal multipliers for the
// epoch seconds to calendar pipeline
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int EPOCH_W = 40;
  localparam int T_W     = 38;   // clamped time fits below 2^38
  localparam int Q_W     = 31;   // time with the low 7 bits dropped
  localparam int DAYS_W  = 22;
  localparam int SOD_W   = 17;   // second of the day
  localparam int YEAR_W  = 14;

  // first second past 9999-12-31 23:59:59, and that last second
  localparam logic [38:0]    T_LIMIT = 39'd253402300800;
  localparam logic [T_W-1:0] T_LAST  = 38'd253402300799;

  // 86400 = 675 << 7
  localparam logic [9:0] DAY_ODD = 10'd675;
  localparam int K_DAY = 41;
  localparam logic [31:0] M_DAY = 32'((64'd1 << K_DAY) / 64'd675 + 64'd1);

  // 3600 = 225 << 4
  localparam logic [16:0] HOUR_SECS = 17'd3600;
  localparam int K_HR = 23;
  localparam logic [15:0] M_HR = 16'((64'd1 << K_HR) / 64'd225 + 64'd1);

  // 60 = 15 << 2
  localparam logic [11:0] MIN_SECS = 12'd60;
  localparam int K_MIN = 14;
  localparam logic [10:0] M_MIN = 11'((64'd1 << K_MIN) / 64'd15 + 64'd1);

  // weekday: day 0 was a thursday
  localparam logic [22:0] WD_BASE = 23'd4;
  localparam logic [22:0] WEEK    = 23'd7;
  localparam int K_WD = 25;
  localparam logic [22:0] M_WD = 23'((64'd1 << K_WD) / 64'd7 + 64'd1);

  // day count from march 1 of year 0
  localparam logic [DAYS_W-1:0] MARCH_OFS = 22'd719468;
  localparam logic [30:0] ERA_MUL  = 31'd400;
  localparam int K_YR = 48;
  localparam logic [30:0] M_YR = 31'((64'd1 << K_YR) / 64'd146097 + 64'd1);

  localparam int K_100 = 21;
  localparam logic [14:0] M_100 = 15'((64'd1 << K_100) / 64'd100 + 64'd1);

  // month = (yday + 31) * 10 / 306, folded into one constant
  localparam int K_MON = 21;
  localparam logic [16:0] M_MON = 17'(((64'd1 << K_MON) / 64'd306 + 64'd1) * 64'd10);
  localparam logic [8:0]  JAN_YDAY = 9'd306;

  // latency of the date path after the day split, and the clock path's own stages
  localparam int DATE_LAT   = 7;
  localparam int CLK_STAGES = 4;
  localparam int CLK_PAD    = DATE_LAT - CLK_STAGES;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
  } clk_fields_t;

endpackage

/* design/epc_split.sv */
// ----------------------------------------------------------------------------
// epc_split
// clamps the time and splits it into a day count and a second of the day
// ----------------------------------------------------------------------------
module epc_split (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [39:0]             epoch_seconds,
  output logic                           out_valid,
  output logic [epc_pkg::DAYS_W-1:0]     days,
  output logic [epc_pkg::SOD_W-1:0]      sod
);
  import epc_pkg::*;

  logic             valid_a, valid_b;
  logic [T_W-1:0]   t_a, t_next;
  logic [Q_W-1:0]   q_b;
  logic [6:0]       low_b;
  logic [62:0]      prod_b;
  logic [DAYS_W-1:0] days_next;
  logic [Q_W-1:0]   day_base, rem;

  // negative clamps to zero, past the last day saturates
  always_comb begin
    if (epoch_seconds[39]) begin
      t_next = '0;
    end else if (epoch_seconds[38:0] >= T_LIMIT) begin
      t_next = T_LAST;
    end else begin
      t_next = epoch_seconds[T_W-1:0];
    end
  end

  always_comb begin
    days_next = prod_b[K_DAY +: DAYS_W];
    day_base  = Q_W'(days_next) * Q_W'(DAY_ODD);
    rem       = q_b - day_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    t_a    <= t_next;
    q_b    <= t_a[T_W-1:7];
    low_b  <= t_a[6:0];
    prod_b <= {32'd0, t_a[T_W-1:7]} * {31'd0, M_DAY};
    days   <= days_next;
    sod    <= {rem[9:0], low_b};
  end

endmodule

/* design/epc_clock.sv */
// ----------------------------------------------------------------------------
// epc_clock
// hour, minute, second and weekday, padded to line up with the date path
// ----------------------------------------------------------------------------
module epc_clock (
  input  logic                         clk,
  input  logic [epc_pkg::DAYS_W-1:0]   days,
  input  logic [epc_pkg::SOD_W-1:0]    sod,
  output epc_pkg::clk_fields_t         fields
);
  import epc_pkg::*;

  logic [28:0]       hp1;
  logic [45:0]       wp1;
  logic [SOD_W-1:0]  sod1;
  logic [22:0]       x1;

  logic [4:0]        hour2;
  logic [11:0]       srem2;
  logic [2:0]        wday2;
  logic [16:0]       hour_secs;
  logic [16:0]       srem_full;
  logic [22:0]       wk_base, wd_full;

  logic [20:0]       mp3;
  logic [11:0]       srem3;
  logic [4:0]        hour3;
  logic [2:0]        wday3;
  logic [5:0]        min4;
  logic [11:0]       min_secs, sec_full;

  // pad[0] is the fourth stage, pad[CLK_PAD] lines up with the date output
  clk_fields_t       pad [CLK_PAD+1];

  always_comb begin
    hour_secs = 17'(hp1[K_HR +: 5]) * HOUR_SECS;
    srem_full = sod1 - hour_secs;
    wk_base   = 23'(wp1[45:K_WD]) * WEEK;
    wd_full   = x1 - wk_base;
    min4      = mp3[K_MIN +: 6];
    min_secs  = 12'(min4) * MIN_SECS;
    sec_full  = srem3 - min_secs;
  end

  always_ff @(posedge clk) begin
    // stage 1: reciprocal products
    hp1   <= 29'(sod[SOD_W-1:4]) * 29'(M_HR);
    wp1   <= 46'(23'(days) + WD_BASE) * 46'(M_WD);
    sod1  <= sod;
    x1    <= 23'(days) + WD_BASE;
    // stage 2: hour and weekday
    hour2 <= hp1[K_HR +: 5];
    srem2 <= srem_full[11:0];
    wday2 <= wd_full[2:0];
    // stage 3: minute product
    mp3   <= 21'(srem2[11:2]) * 21'(M_MIN);
    srem3 <= srem2;
    hour3 <= hour2;
    wday3 <= wday2;
    // stage 4: minute and second, then delay taps
    pad[0] <= '{second: sec_full[5:0], minute: min4, hour: hour3, weekday: wday3};
    for (int i = 1; i <= CLK_PAD; i++) begin
      pad[i] <= pad[i-1];
    end
  end

  assign fields = pad[CLK_PAD];

endmodule

/* design/epc_date.sv */
// ----------------------------------------------------------------------------
// epc_date
// day count to year, month and day of month on a march-based year
// ----------------------------------------------------------------------------
module epc_date (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [epc_pkg::DAYS_W-1:0]   days,
  output logic                         out_valid,
  output logic [4:0]                   day_of_month,
  output logic [3:0]                   month,
  output logic [epc_pkg::YEAR_W-1:0]   year
);
  import epc_pkg::*;

  logic [DATE_LAT-1:0] valid_sr;

  logic [30:0]        num1;
  logic [DAYS_W-1:0]  dd1, dd2, dd3;
  logic [61:0]        yp2;
  logic [YEAR_W-1:0]  y3, y4, y5, y6;
  logic [28:0]        cp3;
  logic [10:0]        yday4;
  logic               leap4;
  logic [8:0]         yd5, yd6;
  logic [25:0]        mp6;

  logic [YEAR_W-1:0]  y3_n;
  logic [6:0]         c100;
  logic [22:0]        cum, dif;
  logic [13:0]        hund;
  logic [13:0]        rem100;
  logic [10:0]        yfix;
  logic [3:0]         mon7;
  logic [8:0]         base7, mday_full;

  // days before the first of month m, march-based: 367 * m / 12 - 30
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd61;
      4'd4:    r = 9'd92;
      4'd5:    r = 9'd122;
      4'd6:    r = 9'd153;
      4'd7:    r = 9'd184;
      4'd8:    r = 9'd214;
      4'd9:    r = 9'd245;
      4'd10:   r = 9'd275;
      4'd11:   r = 9'd306;
      4'd12:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    y3_n      = yp2[K_YR +: YEAR_W];
    c100      = cp3[K_100 +: 7];
    cum       = 23'(y3) * 23'd365 + 23'(y3[YEAR_W-1:2]) - 23'(c100) + 23'(c100[6:2]);
    dif       = 23'(dd3) - cum;
    hund      = 14'(c100) * 14'd100;
    rem100    = y3 - hund;
    yfix      = yday4 + 11'd365 + 11'(leap4);
    mon7      = mp6[K_MON +: 4];
    base7     = month_base(mon7);
    mday_full = yd6 - base7 + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_sr <= '0;
    end else begin
      valid_sr <= {valid_sr[DATE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: shift to march-based count, scale by 400
    dd1   <= days + MARCH_OFS;
    num1  <= (31'(days + MARCH_OFS) + 31'd2) * ERA_MUL;
    // stage 2: year estimate product
    yp2   <= 62'(num1) * 62'(M_YR);
    dd2   <= dd1;
    // stage 3: year, century product
    y3    <= y3_n;
    cp3   <= 29'(y3_n) * 29'(M_100);
    dd3   <= dd2;
    // stage 4: day of year and leap flag
    yday4 <= dif[10:0];
    leap4 <= (y3[1:0] == 2'd0) && ((rem100[6:0] != 7'd0) || (c100[1:0] == 2'd0));
    y4    <= y3;
    // stage 5: take back one year when the day of year is negative
    if (yday4[10]) begin
      yd5 <= yfix[8:0];
      y5  <= y4 - 14'd1;
    end else begin
      yd5 <= yday4[8:0];
      y5  <= y4;
    end
    // stage 6: month product
    mp6   <= 26'(10'(yd5) + 10'd31) * 26'(M_MON);
    yd6   <= yd5;
    y6    <= y5;
    // stage 7: back to january-based month and year
    day_of_month <= mday_full[4:0];
    if (yd6 >= JAN_YDAY) begin
      year  <= y6 + 14'd1;
      month <= mon7 - 4'd10;
    end else begin
      year  <= y6;
      month <= mon7 + 4'd2;
    end
  end

  assign out_valid = valid_sr[DATE_LAT-1];

endmodule

/* design/epoch_seconds_to_calendar.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// signed unix seconds to utc calendar fields, fully pipelined
//
//   channel   signals                              transfer when
//   -------   ----------------------------------   -------------------------
//   input     start, busy, epoch_seconds           start high and busy low
//   result    done, second, minute, hour,          done high (one cycle,
//             day_of_month, month, year, weekday   no back pressure)
//
// one item per clock; each result passes through 10 register stages: the day
// split (3 stages) followed by the year/month path (7 stages)
// busy is high only during reset; rst clears all valid bits in flight
// there are no stalls: the pipeline always advances
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [39:0]  epoch_seconds,
  output logic                done,
  output logic [5:0]          second,
  output logic [5:0]          minute,
  output logic [4:0]          hour,
  output logic [4:0]          day_of_month,
  output logic [3:0]          month,
  output logic [13:0]         year,
  output logic [2:0]          weekday
);
  import epc_pkg::*;

  logic              accept;
  logic              split_valid;
  logic [DAYS_W-1:0] days;
  logic [SOD_W-1:0]  sod;
  clk_fields_t       tod;

  // nothing holds the pipe back except reset
  assign busy   = rst;
  assign accept = start & ~busy;

  // clamp and split into day count plus second of the day
  epc_split u_split (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .epoch_seconds (epoch_seconds),
    .out_valid     (split_valid),
    .days          (days),
    .sod           (sod)
  );

  // time of day and weekday, delayed to match the date path
  epc_clock u_clock (
    .clk    (clk),
    .days   (days),
    .sod    (sod),
    .fields (tod)
  );

  // year, month and day of month; carries the valid bit to done
  epc_date u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (split_valid),
    .days         (days),
    .out_valid    (done),
    .day_of_month (day_of_month),
    .month        (month),
    .year         (year)
  );

  assign second  = tod.second;
  assign minute  = tod.minute;
  assign hour    = tod.hour;
  assign weekday = tod.weekday;

endmodule
